// File: rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  localparam int unsigned DataW    = 32;  // filtered mean, sample, offset, prior mean
  localparam int unsigned VarW     = 31;  // variances
  localparam int unsigned ArCoeffW = 18;  // AR coefficient
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgArCoeff      = 3'd0,
    CfgObsOffset    = 3'd1,
    CfgObsNoiseVar  = 3'd2,
    CfgStateNoiseVar = 3'd3,
    CfgPriorMean    = 3'd4,
    CfgPriorVar     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    series_start;
  } skf_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] filtered_mean;
    logic [VarW-1:0]         filtered_var;
    logic                    saturated;
  } skf_out_t;

endpackage

// File: rtl/scalar_kalman_filter.sv
// Scalar Kalman filter top level: sequencer, bit-serial multipliers and divider.
//
// Each accepted item is one observation of an AR(1) state; the block predicts the kept
// mean and variance forward, corrects them with the gain p / (p + obs_noise_var) and
// returns one item with the filtered mean and variance, which are also kept for the
// next observation (series_start restarts from the configured prior). One item is
// worked on at a time. Two shift-add multipliers retire one multiplier bit per cycle
// and stop early once the remaining multiplier bits are zero, and a restoring divider
// produces one gain bit per cycle. The time from acceptance to a valid result is set
// by the multiplier passes and the FRAC_BITS divide steps, and it is shorter when the
// multipliers are small. A new item can be accepted while the previous result still
// waits on a stalled output.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  skf_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output skf_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  // Magnitude widths of the intermediates.
  localparam int unsigned PhiW    = ArCoeffW;
  localparam int unsigned AMagW   = PhiW + DataW - FRAC_BITS;
  localparam int unsigned Phi2W   = 2 * PhiW - FRAC_BITS;
  localparam int unsigned PProdW  = Phi2W + VarW - FRAC_BITS;
  localparam int unsigned PW      = ((PProdW > VarW) ? PProdW : VarW) + 1;
  localparam int unsigned DenW    = PW + 1;
  localparam int unsigned RemW    = PW + 2;
  localparam int unsigned YW      = DataW + 1;
  localparam int unsigned VW      = ((YW > AMagW + 1) ? YW : AMagW + 1) + 1;
  localparam int unsigned GW      = FRAC_BITS + 1;
  localparam int unsigned MW      = ((AMagW + 1 > VW + 1) ? AMagW + 1 : VW + 1) + 1;
  localparam int unsigned ProdA   = PhiW + DataW;
  localparam int unsigned ProdB   = (ProdA > Phi2W + VarW) ? ProdA : Phi2W + VarW;
  localparam int unsigned ProdC   = (ProdB > VW + GW) ? ProdB : VW + GW;
  localparam int unsigned ProdW   = (ProdC > PW + GW) ? ProdC : PW + GW;
  localparam int unsigned MplA    = (PhiW > Phi2W) ? PhiW : Phi2W;
  localparam int unsigned MplW    = (MplA > GW) ? MplA : GW;
  localparam int unsigned CntW    = $clog2(FRAC_BITS + 1);

  localparam logic [VarW-1:0] OneQ = VarW'(64'd1 << FRAC_BITS);
  localparam logic [GW-1:0]   OneG = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMul1   = 7'b0000010,
    StMul2   = 7'b0000100,
    StDivSet = 7'b0001000,
    StDiv    = 7'b0010000,
    StMul3   = 7'b0100000,
    StFin    = 7'b1000000
  } state_e;

  state_e state_q;

  // Configuration and kept state.
  logic signed [PhiW-1:0]  ar_q;
  logic signed [DataW-1:0] off_q;
  logic [VarW-1:0]         onv_q;
  logic [VarW-1:0]         snv_q;
  logic signed [DataW-1:0] pm_q;
  logic [VarW-1:0]         pv_q;
  logic signed [DataW-1:0] mean_q;
  logic [VarW-1:0]         var_q;

  // Datapath registers.
  logic [VarW-1:0]         prevp_q;
  logic signed [YW-1:0]    y_q;
  logic                    neg_a_q;
  logic signed [AMagW:0]   a_q;
  logic [PW-1:0]           p_q;
  logic [DenW-1:0]         den_q;
  logic signed [VW-1:0]    v_q;
  logic [RemW-1:0]         rem_q;
  logic [GW-1:0]           gain_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [VW:0]      corr_q;
  logic [PW-1:0]           pn_q;
  logic [ProdW-1:0]        xmc_q, xacc_q, ymc_q, yacc_q;
  logic [MplW-1:0]         xml_q, yml_q;

  logic                    out_valid_q;
  skf_out_t                out_q;

  // Input selection and operand magnitudes.
  logic signed [DataW-1:0] prev_m;
  logic [VarW-1:0]         prev_p;
  logic [PhiW-1:0]         phi_mag;
  logic [DataW-1:0]        m_mag;
  logic signed [YW-1:0]    y_d;
  logic                    accept;

  assign accept  = in_valid_i && (state_q == StIdle);
  assign prev_m  = in_data_i.series_start ? pm_q : mean_q;
  assign prev_p  = in_data_i.series_start ? pv_q : var_q;
  assign phi_mag = ar_q[PhiW-1] ? (~ar_q + 1'b1) : ar_q;
  assign m_mag   = prev_m[DataW-1] ? (~prev_m + 1'b1) : prev_m;
  assign y_d     = YW'(in_data_i.sample) - YW'(off_q);

  // Shift-add step shared by all multiplier passes.
  logic [ProdW-1:0] x_add, y_add;
  logic             mul_done;

  assign x_add    = xml_q[0] ? (xacc_q + xmc_q) : xacc_q;
  assign y_add    = yml_q[0] ? (yacc_q + ymc_q) : yacc_q;
  assign mul_done = (xml_q == '0) && (yml_q == '0);

  // Handoff values between passes.
  logic [AMagW-1:0]        a_mag;
  logic [AMagW:0]          a_ext;
  logic signed [AMagW:0]   a_d;
  logic [Phi2W-1:0]        phi2;
  logic [PW-1:0]           p_d;
  logic [DenW-1:0]         den_d;
  logic signed [VW-1:0]    v_d;
  logic [VW-1:0]           v_mag;
  logic                    div_short;
  logic [GW-1:0]           gain_fin;
  logic [RemW-1:0]         rem_sh;
  logic                    rem_ge;
  logic [VW:0]             corr_ext;
  logic signed [VW:0]      corr_d;
  logic [PW-1:0]           pn_d;

  assign a_mag     = xacc_q[FRAC_BITS +: AMagW];
  assign a_ext     = {1'b0, a_mag};
  assign a_d       = neg_a_q ? (~a_ext + 1'b1) : a_ext;
  assign phi2      = yacc_q[FRAC_BITS +: Phi2W];
  assign p_d       = PW'(xacc_q[FRAC_BITS +: PProdW]) + PW'(snv_q);
  assign den_d     = DenW'(p_q) + DenW'(onv_q);
  assign v_d       = VW'(y_q) - VW'(a_q);
  assign v_mag     = v_q[VW-1] ? (~v_q + 1'b1) : v_q;
  // With no observation noise the gain is one, or zero when the predicted variance is too.
  assign div_short = (onv_q == '0);
  assign gain_fin  = div_short ? ((p_q == '0) ? '0 : OneG) : gain_q;
  assign rem_sh    = {rem_q[RemW-2:0], 1'b0};
  assign rem_ge    = (rem_sh >= RemW'(den_q));
  assign corr_ext  = {1'b0, xacc_q[FRAC_BITS +: VW]};
  assign corr_d    = v_q[VW-1] ? (~corr_ext + 1'b1) : corr_ext;
  assign pn_d      = p_q - yacc_q[FRAC_BITS +: PW];

  // Final sum and clipping.
  logic signed [MW-1:0]    m_sum;
  logic                    m_ok;
  logic [DataW-1:0]        fin_mean;
  logic                    v_ok;
  logic [VarW-1:0]         fin_var;
  logic                    fire;

  assign m_sum    = MW'(a_q) + MW'(corr_q);
  assign m_ok     = (&m_sum[MW-1:DataW-1]) || !(|m_sum[MW-1:DataW-1]);
  assign fin_mean = m_ok ? m_sum[DataW-1:0]
                  : (m_sum[MW-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}});
  assign v_ok     = !(|pn_q[PW-1:VarW]);
  assign fin_var  = v_ok ? pn_q[VarW-1:0] : {VarW{1'b1}};
  assign fire     = (state_q == StFin) && !(out_valid_q && out_stall_i);

  // Control, configuration and kept state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      ar_q        <= '0;
      off_q       <= '0;
      onv_q       <= OneQ;
      snv_q       <= OneQ;
      pm_q        <= '0;
      pv_q        <= OneQ;
      mean_q      <= '0;
      var_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgArCoeff:       ar_q  <= cfg_data_i[PhiW-1:0];
          CfgObsOffset:     off_q <= cfg_data_i[DataW-1:0];
          CfgObsNoiseVar:   onv_q <= cfg_data_i[VarW-1:0];
          CfgStateNoiseVar: snv_q <= cfg_data_i[VarW-1:0];
          CfgPriorMean:     pm_q  <= cfg_data_i[DataW-1:0];
          CfgPriorVar:      pv_q  <= cfg_data_i[VarW-1:0];
          default: ;
        endcase
      end

      if (fire) begin
        out_valid_q <= 1'b1;
        mean_q      <= fin_mean;
        var_q       <= fin_var;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) state_q <= StMul1;
        end
        StMul1: begin
          if (mul_done) state_q <= StMul2;
        end
        StMul2: begin
          if (mul_done) state_q <= StDivSet;
        end
        StDivSet: state_q <= StDiv;
        StDiv: begin
          if (div_short || (cnt_q == '0)) state_q <= StMul3;
        end
        StMul3: begin
          if (mul_done) state_q <= StFin;
        end
        StFin: begin
          if (fire) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.filtered_mean <= fin_mean;
      out_q.filtered_var  <= fin_var;
      out_q.saturated     <= !m_ok || !v_ok;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          xml_q   <= MplW'(phi_mag);
          xmc_q   <= ProdW'(m_mag);
          xacc_q  <= '0;
          yml_q   <= MplW'(phi_mag);
          ymc_q   <= ProdW'(phi_mag);
          yacc_q  <= '0;
          neg_a_q <= ar_q[PhiW-1] ^ prev_m[DataW-1];
          prevp_q <= prev_p;
          y_q     <= y_d;
        end
      end
      StMul1, StMul2, StMul3: begin
        if (!mul_done) begin
          xacc_q <= x_add;
          xmc_q  <= xmc_q << 1;
          xml_q  <= xml_q >> 1;
          yacc_q <= y_add;
          ymc_q  <= ymc_q << 1;
          yml_q  <= yml_q >> 1;
        end else if (state_q == StMul1) begin
          // The coefficient squared times the previous variance comes next.
          a_q    <= a_d;
          xml_q  <= MplW'(phi2);
          xmc_q  <= ProdW'(prevp_q);
          xacc_q <= '0;
        end else if (state_q == StMul2) begin
          p_q <= p_d;
        end else begin
          corr_q <= corr_d;
          pn_q   <= pn_d;
        end
      end
      StDivSet: begin
        den_q  <= den_d;
        v_q    <= v_d;
        rem_q  <= RemW'(p_q);
        gain_q <= '0;
        cnt_q  <= CntW'(FRAC_BITS);
      end
      StDiv: begin
        if (div_short || (cnt_q == '0)) begin
          xml_q  <= MplW'(gain_fin);
          xmc_q  <= ProdW'(v_mag);
          xacc_q <= '0;
          yml_q  <= MplW'(gain_fin);
          ymc_q  <= ProdW'(p_q);
          yacc_q <= '0;
        end else begin
          rem_q  <= rem_ge ? (rem_sh - RemW'(den_q)) : rem_sh;
          gain_q <= {gain_q[GW-2:0], rem_ge};
          cnt_q  <= cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the scalar Kalman filter: directed and random observations.
`timescale 1ns / 100ps

module tb_top import skf_pkg::*; ();

  localparam int FracBits = 16;
  localparam longint Lim = longint'(1) << 61;
  localparam longint unsigned One = longint'(1) << FracBits;
  localparam longint DMax = (longint'(1) << (DataW - 1)) - 1;
  localparam longint DMin = -DMax - 1;
  localparam int CycleLimit = 1_000_000;

  // Bit-exact predictor of the filter plus the queue of estimates still owed by the block.
  class skf_scoreboard;
    logic signed [ArCoeffW-1:0] ar_coeff;
    logic signed [DataW-1:0]    obs_offset;
    logic [VarW-1:0]            obs_noise_var;
    logic [VarW-1:0]            state_noise_var;
    logic signed [DataW-1:0]    prior_mean;
    logic [VarW-1:0]            prior_var;
    logic signed [DataW-1:0]    mean_reg;
    logic [VarW-1:0]            var_reg;
    bit                         clipped;
    skf_out_t                   pending_estimates[$];
    int                         errors;

    function new();
      ar_coeff = '0;
      obs_offset = '0;
      obs_noise_var = VarW'(One);
      state_noise_var = VarW'(One);
      prior_mean = '0;
      prior_var = VarW'(One);
      mean_reg = '0;
      var_reg = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
      case (idx)
        CfgArCoeff:       ar_coeff = d[ArCoeffW-1:0];
        CfgObsOffset:     obs_offset = d[DataW-1:0];
        CfgObsNoiseVar:   obs_noise_var = d[VarW-1:0];
        CfgStateNoiseVar: state_noise_var = d[VarW-1:0];
        CfgPriorMean:     prior_mean = d[DataW-1:0];
        CfgPriorVar:      prior_var = d[VarW-1:0];
        default: ;
      endcase
    endfunction

    // Fixed-point product of two magnitudes, truncated, clamped to the intermediate limit.
    function longint unsigned umul_frac(longint unsigned x, longint unsigned y);
      logic [127:0] prod;
      prod = ({64'd0, x} * {64'd0, y}) >> FracBits;
      if (prod > Lim) begin
        clipped = 1'b1;
        return Lim;
      end
      return prod[63:0];
    endfunction

    // Signed product rounds toward zero, so it works on magnitudes.
    function longint smul_frac(longint x, longint y);
      longint unsigned mx, my, r;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      r = umul_frac(mx, my);
      return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function longint clamp_lim(longint x);
      if (x > Lim) begin
        clipped = 1'b1;
        return Lim;
      end
      if (x < -Lim) begin
        clipped = 1'b1;
        return -Lim;
      end
      return x;
    endfunction

    function skf_out_t kalman_update(skf_in_t it);
      longint prev_m, y, phi, a, v, m_new, p_new;
      longint unsigned prev_p, phi2, p, den, gain;
      logic [127:0] num;
      skf_out_t res;
      clipped = 1'b0;
      if (it.series_start) begin
        prev_m = prior_mean;
        prev_p = prior_var;
      end else begin
        prev_m = mean_reg;
        prev_p = var_reg;
      end
      y = $signed(it.sample) - $signed(obs_offset);
      phi = ar_coeff;
      a = smul_frac(phi, prev_m);
      phi2 = smul_frac(phi, phi);
      p = umul_frac(phi2, prev_p) + state_noise_var;
      if (p > Lim) begin
        clipped = 1'b1;
        p = Lim;
      end
      v = clamp_lim(y - a);
      den = p + obs_noise_var;
      gain = 0;
      if (den != 0) begin
        if (p >= den) begin
          gain = One;
        end else begin
          num = ({64'd0, p} << FracBits) / {64'd0, den};
          gain = num[63:0];
        end
      end
      m_new = clamp_lim(a + smul_frac(v, longint'(gain)));
      p_new = longint'(p) - longint'(umul_frac(gain, p));
      if (p_new < 0) p_new = 0;
      if (m_new > DMax) begin
        m_new = DMax;
        clipped = 1'b1;
      end
      if (m_new < DMin) begin
        m_new = DMin;
        clipped = 1'b1;
      end
      if (p_new > DMax) begin
        p_new = DMax;
        clipped = 1'b1;
      end
      mean_reg = m_new[DataW-1:0];
      var_reg = p_new[VarW-1:0];
      res.filtered_mean = mean_reg;
      res.filtered_var = var_reg;
      res.saturated = clipped;
      return res;
    endfunction

    function void accept_observation(skf_in_t it);
      pending_estimates.push_back(kalman_update(it));
    endfunction

    function void check_estimate(skf_out_t got);
      skf_out_t want;
      if (pending_estimates.size() == 0) begin
        $error("unexpected item on the output with no observation outstanding");
        errors++;
        return;
      end
      want = pending_estimates.pop_front();
      if (got.filtered_mean !== want.filtered_mean) begin
        $error("filtered_mean: expected %0d, got %0d",
               $signed(want.filtered_mean), $signed(got.filtered_mean));
        errors++;
      end
      if (got.filtered_var !== want.filtered_var) begin
        $error("filtered_var: expected %0d, got %0d", want.filtered_var, got.filtered_var);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_estimates.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  skf_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  skf_out_t            out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  skf_scoreboard sb = new();
  int send_idle_max = 11;
  int recv_idle_max = 11;
  int stall_delay = 0;
  int stall_left = 0;
  int cycle_count = 0;

  scalar_kalman_filter #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // After each accepted item, stay ready a random while and then stall a random while.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_estimate(out_data_o);
        stall_delay = $urandom_range(0, 60);
        stall_left = $urandom_range(0, recv_idle_max);
      end else if (stall_delay > 0) begin
        stall_delay--;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_delay == 0 && stall_left > 0);
    end
  end

  task automatic send_item(logic [DataW-1:0] sample, bit start);
    int gap;
    skf_in_t it;
    gap = $urandom_range(0, send_idle_max);
    it.sample = sample;
    it.series_start = start;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.accept_observation(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    sb.set_reg(idx, d);
    @(posedge clk_i);
  endtask

  task automatic write_settings(logic [CfgDataW-1:0] ar, off, onv, snv, pm, pv);
    write_reg(CfgArCoeff, ar);
    write_reg(CfgObsOffset, off);
    write_reg(CfgObsNoiseVar, onv);
    write_reg(CfgStateNoiseVar, snv);
    write_reg(CfgPriorMean, pm);
    write_reg(CfgPriorVar, pv);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_setting(cfg_idx_e idx);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    case (idx)
      CfgArCoeff: begin
        case (sel)
          1: return 32'h0001_FFFF;
          2: return 32'hFFFE_0000;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          default: return $urandom_range(0, 131072) - 65536;
        endcase
      end
      CfgObsOffset, CfgPriorMean: begin
        case (sel)
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
      end
      default: begin
        case (sel)
          1: return 32'h0;
          2: return 32'h7FFF_FFFF;
          default: return $urandom_range(0, 1 << 20);
        endcase
      end
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel < 4) return $urandom;
    if (sel == 4) return 32'h7FFF_FFFF;
    if (sel == 5) return 32'h8000_0000;
    return sb.obs_offset + ($urandom_range(0, 1 << 22) - (1 << 21));
  endfunction

  // Mostly whole series opened by a start flag; now and then a series without one,
  // or a stray restart in the middle.
  task automatic run_series(int count);
    int left, len;
    bit start;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 24);
      for (int k = 0; k < len && left > 0; k++) begin
        if (k == 0) start = ($urandom_range(0, 9) != 0);
        else start = ($urandom_range(0, 29) == 0);
        send_item(pick_sample(), start);
        left--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings; the first item runs on the cleared state.
    send_item(32'h0, 1'b0);
    send_item(32'h0, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Largest coefficient, no observation noise: the gain is exactly one and results clip.
    write_settings(32'h0001_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0, 1'b0);
    wait_idle();

    write_settings(32'hFFFE_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                   32'h8000_0000, 32'h0);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0, 1'b0);
    wait_idle();

    // Both variances zero: the gain denominator vanishes.
    write_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send_item(32'h0000_3039, 1'b1);
    send_item(32'hFFFF_FFFB, 1'b0);
    wait_idle();

    write_settings(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'hFFF0_0000, 32'h0);
    send_item(32'h0002_0000, 1'b1);
    send_item(32'hFFFE_0000, 1'b0);
    send_item(32'h0000_8000, 1'b0);
    wait_idle();

    write_settings(32'hFFFF_0000, 32'h0001_0000, 32'h0000_4000, 32'h0000_2000,
                   32'h0003_0000, 32'h0002_0000);
    send_item(32'h0005_0000, 1'b1);
    send_item(32'hFFFB_0000, 1'b0);
    send_item(32'h0001_0000, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      send_idle_max = (ph % 4 >= 2) ? 0 : 11;
      recv_idle_max = (ph % 4 == 2) ? 0 : 11;
      write_settings(pick_setting(CfgArCoeff), pick_setting(CfgObsOffset),
                     pick_setting(CfgObsNoiseVar), pick_setting(CfgStateNoiseVar),
                     pick_setting(CfgPriorMean), pick_setting(CfgPriorVar));
      run_series(100);
    end

    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.outstanding() != 0) $error("%0d estimates never arrived", sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
